@@ rtl/sle_pkg.sv @@
package sle_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 5;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_CAN   = 8'h18;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_BS,
    CMD_CAN,
    CMD_EOL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERASE,
    BK_LINE
  } bk_state_t;

endpackage

@@ rtl/sle_if.sv @@
interface sle_rx_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_char;
  logic              rx_error;
  modport source (output valid, output rx_char, output rx_error, input ready);
  modport sink   (input valid, input rx_char, input rx_error, output ready);
endinterface

interface sle_out_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              kind;
  logic [LEN_W-1:0]  line_length;
  logic              last;
  modport source (output valid, output out_char, output kind, output line_length,
                  output last, input ready);
  modport sink   (input valid, input out_char, input kind, input line_length,
                  input last, output ready);
endinterface

interface sle_cfg_if;
  import sle_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sle_front.sv @@
module sle_front (
  input  logic            clk,
  input  logic            rst,
  sle_rx_if.sink         rx,
  output logic            cmd_valid,
  output sle_pkg::cmd_t   cmd,
  input  logic            cmd_ready
);
  import sle_pkg::*;

  logic  keep;
  cmd_t  cmd_new;
  logic  rx_take;

  // classify the byte; errors, high bytes and unknown controls are dropped
  always_comb begin
    keep       = 1'b0;
    cmd_new.op = CMD_PUT;
    cmd_new.ch = rx.rx_char;
    if (!rx.rx_error && !rx.rx_char[CHAR_W-1]) begin
      if (rx.rx_char inside {CH_CR, CH_LF}) begin
        keep       = 1'b1;
        cmd_new.op = CMD_EOL;
      end else if (rx.rx_char == CH_BS) begin
        keep       = 1'b1;
        cmd_new.op = CMD_BS;
      end else if (rx.rx_char == CH_CAN) begin
        keep       = 1'b1;
        cmd_new.op = CMD_CAN;
      end else if (rx.rx_char >= CH_SPACE) begin
        keep       = 1'b1;
        cmd_new.op = CMD_PUT;
      end
    end
  end

  assign rx.ready = !cmd_valid || cmd_ready;
  assign rx_take  = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (rx_take) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      cmd <= cmd_new;
    end
  end

endmodule

@@ rtl/sle_queue.sv @@
module sle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  sle_pkg::cmd_t  in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  output sle_pkg::cmd_t  out_cmd,
  input  logic           out_ready
);
  import sle_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;
  logic            push;
  logic            pop;

  assign in_ready  = fill != (Q_AW+1)'(Q_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

endmodule

@@ rtl/sle_back.sv @@
module sle_back #(
  parameter int LINE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [sle_pkg::LEN_W-1:0] line_limit,
  input  logic                     cmd_valid,
  input  sle_pkg::cmd_t            cmd,
  output logic                     cmd_ready,
  sle_out_if.source                res
);
  import sle_pkg::*;

  localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [CHAR_W-1:0] store [LINE_DEPTH];

  bk_state_t         state, state_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [LEN_W-1:0]  er_left, er_left_next;
  logic [LEN_W-1:0]  er_len, er_len_next;
  logic [1:0]        ph, ph_next;
  logic [LEN_W-1:0]  rd, rd_next;
  logic [LEN_W-1:0]  done, done_next;

  logic              adv;
  logic              load;
  logic              rd_sel;
  logic              st_we;
  logic [CHAR_W-1:0] o_char;
  logic              o_kind;
  logic [LEN_W-1:0]  o_len;
  logic              o_last;
  logic [LEN_W-1:0]  limit_eff;

  assign adv       = !res.valid || res.ready;
  assign limit_eff = (line_limit > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : line_limit;

  always_comb begin
    state_next   = state;
    count_next   = count;
    er_left_next = er_left;
    er_len_next  = er_len;
    ph_next      = ph;
    rd_next      = rd;
    done_next    = done;
    cmd_ready    = 1'b0;
    load         = 1'b0;
    rd_sel       = 1'b0;
    st_we        = 1'b0;
    o_char       = CH_BS;
    o_kind       = 1'b0;
    o_len        = '0;
    o_last       = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = adv;
        if (cmd_valid && adv) begin
          case (cmd.op)
            CMD_PUT: begin
              if (count < limit_eff) begin
                st_we      = 1'b1;
                count_next = count + LEN_W'(1);
                load       = 1'b1;
                o_char     = cmd.ch;
                o_len      = count + LEN_W'(1);
                o_last     = 1'b1;
              end
            end
            CMD_BS: begin
              if (count != '0) begin
                count_next   = count - LEN_W'(1);
                load         = 1'b1;
                o_char       = CH_BS;
                o_len        = count - LEN_W'(1);
                er_left_next = LEN_W'(1);
                er_len_next  = count - LEN_W'(1);
                ph_next      = 2'd1;
                state_next   = BK_ERASE;
              end
            end
            CMD_CAN: begin
              if (count != '0) begin
                count_next   = '0;
                load         = 1'b1;
                o_char       = CH_BS;
                o_len        = '0;
                er_left_next = count;
                er_len_next  = '0;
                ph_next      = 2'd1;
                state_next   = BK_ERASE;
              end
            end
            CMD_EOL: begin
              count_next = '0;
              load       = 1'b1;
              o_char     = CH_LF;
              o_len      = '0;
              o_last     = count == '0;
              done_next  = count;
              rd_next    = '0;
              if (count != '0) begin
                state_next = BK_LINE;
              end
            end
            default: ;
          endcase
        end
      end
      BK_ERASE: begin
        if (adv) begin
          load   = 1'b1;
          o_char = (ph == 2'd1) ? CH_SPACE : CH_BS;
          o_len  = er_len;
          o_last = (er_left == LEN_W'(1)) && (ph == 2'd2);
          if (ph == 2'd2) begin
            ph_next      = 2'd0;
            er_left_next = er_left - LEN_W'(1);
          end else begin
            ph_next = ph + 2'd1;
          end
          if (o_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_LINE: begin
        if (adv) begin
          load    = 1'b1;
          rd_sel  = 1'b1;
          o_kind  = 1'b1;
          o_len   = done;
          o_last  = rd == (done - LEN_W'(1));
          rd_next = rd + LEN_W'(1);
          if (o_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    er_left <= er_left_next;
    er_len  <= er_len_next;
    ph      <= ph_next;
    rd      <= rd_next;
    done    <= done_next;
    if (st_we) begin
      store[count[IDX_W-1:0]] <= cmd.ch;
    end
    if (load) begin
      res.out_char    <= rd_sel ? store[rd[IDX_W-1:0]] : o_char;
      res.kind        <= o_kind;
      res.line_length <= o_len;
      res.last        <= o_last;
    end
  end

endmodule

@@ rtl/serial_line_editor.sv @@
// serial line editor: echo and line assembly for a received byte stream
// an accepted request passes the front command register and the queue before its first result is registered
// throughput: one result per cycle while the consumer is ready; a request holds the back end
//   until it has emitted all of its results (up to 3 * LINE_DEPTH)
// reset: synchronous, clears the line length, command queue and output valid;
//   line_limit returns to 16; the line store itself is not cleared
module serial_line_editor #(
  parameter int LINE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  sle_rx_if.sink   rx,
  sle_cfg_if.sink  cfg,
  sle_out_if.source res
);
  import sle_pkg::*;

  // line limit register; the user must write it only while the editor is quiet, the block does not enforce it
  logic [LEN_W-1:0] line_limit;

  // front to queue
  logic  f_valid;
  cmd_t  f_cmd;
  logic  f_ready;

  // queue to back
  logic  q_valid;
  cmd_t  q_cmd;
  logic  q_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LEN_W'(16);
    end else if (cfg.valid && cfg.ready) begin
      line_limit <= cfg.data;
    end
  end

  // front: classify each received byte into an edit command, drop the rest
  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // short command queue so the receiver side keeps moving during long echoes
  sle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  // back: owns the line store and length, sequences the echo and line results
  sle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .line_limit (line_limit),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_ready  (q_ready),
    .res        (res)
  );

endmodule

@@ rtl/sle_checker.sv @@
module sle_checker #(
  parameter int LINE_DEPTH = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [sle_pkg::CHAR_W-1:0] out_char,
  input logic                      kind,
  input logic [sle_pkg::LEN_W-1:0]  line_length,
  input logic                      last
);
  import sle_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_char) && $stable(kind)
      && $stable(line_length) && $stable(last))
    else $error("result changed while stalled");

  // a line byte always belongs to a nonempty line
  a_line_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind |-> line_length != '0)
    else $error("line result with zero length");

  // echo bytes are printable, backspace or line feed
  a_echo_char: assert property (@(posedge clk) disable iff (rst)
    res_valid && !kind |-> !out_char[CHAR_W-1]
      && (out_char >= CH_SPACE || out_char == CH_BS || out_char == CH_LF))
    else $error("unexpected echo byte");

  // line length never exceeds the store depth
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> line_length <= LEN_W'(LINE_DEPTH))
    else $error("line length beyond store depth");

endmodule

bind serial_line_editor sle_checker #(
  .LINE_DEPTH (LINE_DEPTH)
) u_sle_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .out_char    (res.out_char),
  .kind        (res.kind),
  .line_length (res.line_length),
  .last        (res.last)
);

@@ test/serial_line_editor_test.sv @@
module serial_line_editor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int LINE_DEPTH   = 16;
  localparam int IDX_W        = $clog2(LINE_DEPTH);
  localparam int QUIET_CYCLES = 16;        // back end drains a few ignored requests
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PRINT_LIMIT  = 200;
  localparam int LONG_HOLD_CYCLES = 400;

  // result kinds on the output channel
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              kind;
    logic [LEN_W-1:0]  line_length;
    logic              last;
  } editor_result_t;

  logic clk = 1'b0;
  logic rst;

  sle_rx_if  rx_ch ();
  sle_cfg_if cfg_ch ();
  sle_out_if res_ch ();

  serial_line_editor #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .cfg(cfg_ch),
    .res(res_ch)
  );

  // 10 ns clock
  always #5ns clk = ~clk;

  // shadow of the editor: line contents, length and the limit register
  logic [CHAR_W-1:0] line_bytes [LINE_DEPTH];
  logic [LEN_W-1:0]  line_len  = '0;
  logic [LEN_W-1:0]  limit_cfg = LEN_W'(16);

  editor_result_t pending_results [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;
  logic long_hold    = 1'b0;

  task automatic report_mismatch(input string what);
    // keep the log short when the block is badly broken
    if (error_count < PRINT_LIMIT)
      $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // apply one received byte to the shadow line and queue the results it causes
  task automatic edit_line(input logic [CHAR_W-1:0] c, input logic err);
    editor_result_t burst [$];
    int room;
    int done;
    int erased;
    int i;
    // a limit above the store depth acts as the depth
    room = (int'(limit_cfg) > LINE_DEPTH) ? LINE_DEPTH : int'(limit_cfg);
    // receive errors and bytes with the top bit set are dropped outright
    if (!err && !c[CHAR_W-1]) begin
      if (c == CH_CR || c == CH_LF) begin
        // line end: lf echo first, then the stored bytes as one line
        done = int'(line_len);
        line_len = '0;
        burst.push_back('{out_char: CH_LF, kind: KIND_ECHO, line_length: '0, last: 1'b0});
        for (i = 0; i < done; i++)
          burst.push_back('{out_char: line_bytes[i[IDX_W-1:0]], kind: KIND_LINE,
                            line_length: done[LEN_W-1:0], last: 1'b0});
      end else if (c == CH_BS || c == CH_CAN) begin
        // backspace erases one byte, ctrl-x all of them; each erase echoes bs, space, bs
        // carrying the length left after the edit
        erased = (c == CH_BS) ? ((line_len != '0) ? 1 : 0) : int'(line_len);
        line_len = line_len - erased[LEN_W-1:0];
        for (i = 0; i < 3 * erased; i++)
          burst.push_back('{out_char: (i % 3 == 1) ? CH_SPACE : CH_BS, kind: KIND_ECHO,
                            line_length: line_len, last: 1'b0});
      end else if (c >= CH_SPACE) begin
        // printable: stored and echoed only while the line has room
        if (int'(line_len) < room) begin
          line_bytes[line_len[IDX_W-1:0]] = c;
          line_len = line_len + LEN_W'(1);
          burst.push_back('{out_char: c, kind: KIND_ECHO, line_length: line_len, last: 1'b0});
        end
      end
      // any other control byte falls through with no results
    end
    if (burst.size() != 0)
      burst[burst.size() - 1].last = 1'b1;
    foreach (burst[j])
      pending_results.push_back(burst[j]);
  endtask

  // watch all three channels at each edge: register writes and requests feed
  // the shadow, results are checked against the oldest expectation
  always @(posedge clk) begin
    editor_result_t got;
    editor_result_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        limit_cfg = cfg_ch.data;
      if (rx_ch.valid && rx_ch.ready)
        edit_line(rx_ch.rx_char, rx_ch.rx_error);
      if (res_ch.valid && res_ch.ready) begin
        got = '{out_char: res_ch.out_char, kind: res_ch.kind,
                line_length: res_ch.line_length, last: res_ch.last};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result char %h kind %b len %0d last %b",
                                    got.out_char, got.kind, got.line_length, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got.out_char !== want.out_char || got.kind !== want.kind ||
              got.line_length !== want.line_length || got.last !== want.last)
            report_mismatch($sformatf(
              "got char %h kind %b len %0d last %b, want char %h kind %b len %0d last %b",
              got.out_char, got.kind, got.line_length, got.last,
              want.out_char, want.kind, want.line_length, want.last));
        end
      end
    end
  end

  // result consumer: a long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (long_hold) begin
      res_ch.ready <= 1'b0;
      stall_left   <= LONG_HOLD_CYCLES;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("serial_line_editor_test: errors");
      $finish;
    end
  end

  // offer one byte; returns at the edge where the request is taken
  // valid stays high so back-to-back requests need no extra step
  task automatic offer_byte(input logic [CHAR_W-1:0] c, input logic err);
    if ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    rx_ch.valid    <= 1'b1;
    rx_ch.rx_char  <= c;
    rx_ch.rx_error <= err;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_line_idle();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_limit(input int value);
    wait_line_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // printable echo at both ends of the range, a full line end, an empty line end
  task automatic test_echo_and_line_end();
    offer_byte(8'h41, 1'b0);
    offer_byte(CH_SPACE, 1'b0);
    offer_byte(8'h7E, 1'b0);
    offer_byte(8'h7F, 1'b0);
    offer_byte(CH_CR, 1'b0);
    offer_byte(CH_LF, 1'b0);
  endtask

  // bytes the editor drops: receive errors, high bytes, stray controls,
  // erase on an empty line
  task automatic test_ignored_input();
    offer_byte(8'h41, 1'b1);
    offer_byte(CH_CR, 1'b1);
    offer_byte(8'h80, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'h1F, 1'b0);
    offer_byte(CH_BS, 1'b0);
    offer_byte(CH_CAN, 1'b0);
  endtask

  // backspace and ctrl-x on a line with content
  task automatic test_erase();
    offer_byte(8'h61, 1'b0);
    offer_byte(8'h62, 1'b0);
    offer_byte(8'h63, 1'b0);
    offer_byte(CH_BS, 1'b0);
    offer_byte(CH_CAN, 1'b0);
    offer_byte(8'h78, 1'b0);
    offer_byte(8'h79, 1'b0);
    offer_byte(CH_LF, 1'b0);
  endtask

  // zero limit blocks every printable, a small limit truncates the line
  task automatic test_line_limit();
    write_limit(0);
    offer_byte(8'h71, 1'b0);
    offer_byte(CH_CR, 1'b0);
    write_limit(2);
    offer_byte(8'h61, 1'b0);
    offer_byte(8'h62, 1'b0);
    offer_byte(8'h63, 1'b0);
    offer_byte(CH_CR, 1'b0);
  endtask

  // consumer holds off long enough for the block to fill and stall its input,
  // then the sender pauses until everything is out
  task automatic test_backpressure();
    write_limit(16);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold <= 1'b1;
    @(posedge clk);
    long_hold <= 1'b0;
    repeat (12) offer_byte(8'h70, 1'b0);
    offer_byte(CH_CR, 1'b0);
    wait_line_idle();
    repeat (5) offer_byte(8'h2A, 1'b0);
    offer_byte(CH_CAN, 1'b0);
  endtask

  // mostly well-formed lines with random content, some noise mixed in;
  // only edit bytes (printable, backspace, ctrl-x, line ends) count toward the total
  task automatic test_random_lines(input int count, input int s_pct, input int r_pct,
                                   input int limit);
    int taken;
    int pick;
    logic [CHAR_W-1:0] c;
    write_limit(limit);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // receive error on any byte
        offer_byte(CHAR_W'($urandom_range(255)), 1'b1);
      end else if (pick < 10) begin
        offer_byte(CHAR_W'($urandom_range(255, 128)), 1'b0);
      end else if (pick < 13) begin
        // stray control byte
        do c = CHAR_W'($urandom_range(31));
        while (c == CH_BS || c == CH_CAN || c == CH_CR || c == CH_LF);
        offer_byte(c, 1'b0);
      end else begin
        if (pick < 18)
          c = CH_BS;
        else if (pick < 20)
          c = CH_CAN;
        else if (pick < 25)
          c = ($urandom_range(1) != 0) ? CH_CR : CH_LF;
        else
          c = CHAR_W'($urandom_range(127, 32));
        offer_byte(c, 1'b0);
        taken++;
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_char  <= '0;
    rx_ch.rx_error <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_echo_and_line_end();
    test_ignored_input();
    test_erase();
    test_line_limit();
    test_backpressure();
    // four random phases, each with its own limit; a limit past the depth acts as 16
    test_random_lines(16, 0, 0, 16);
    test_random_lines(16, 88, 0, 31);
    test_random_lines(16, 0, 88, 4);
    test_random_lines(16, 34, 34, 1);

    wait_line_idle();
    if (error_count == 0)
      $display("serial_line_editor_test: clean");
    else
      $display("serial_line_editor_test: errors");
    $finish;
  end

endmodule
